### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge of clk outside of reset.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check a condition on every rising edge of clk outside of reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");

`endif

### hw/rtl/aldag_pkg.sv
// Types and constants of the ARM load decoder and address generator.
package aldag_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_LOAD     = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_UNPRED   = 2'd2,
        ST_LDRT     = 2'd3
    } status_t;

    // Kind of decoded operation held in the queue
    typedef enum logic {
        OP_SINGLE = 1'b0,
        OP_MULTI  = 1'b1
    } op_kind_t;

    // Encoding match patterns
    localparam logic [3:0] LIT_OPC   = 4'd5;     // bits 27..24 of LDR literal
    localparam logic [6:0] LIT_RN    = 7'h1f;    // bits 22..16 of LDR literal
    localparam logic [2:0] LDR_OPC   = 3'd2;     // bits 27..25 of LDR immediate
    localparam logic [5:0] LDM_OPC   = 6'h22;    // bits 27..22 of LDM increment-after
    localparam logic [3:0] PC_REG    = 4'd15;
    localparam logic [31:0] PC_AHEAD = 32'd8;    // PC reads as instruction address plus 8
    localparam logic [31:0] WORD_BYTES = 32'd4;
    localparam int          NUM_REGS = 16;

    // Decoded operation passed from front to back
    typedef struct packed {
        op_kind_t      kind;
        status_t       status;
        logic [3:0]    cond;
        logic [3:0]    dest_reg;
        logic [31:0]   load_address;   // base address for a multiple load
        logic          wb_valid;
        logic [3:0]    wb_reg;
        logic [31:0]   wb_value;       // unused for a multiple load
        logic          pc_loaded;
        logic [NUM_REGS-1:0] reg_list;
    } op_t;

    // One result item
    typedef struct packed {
        status_t     status;
        logic [3:0]  cond;
        logic [3:0]  dest_reg;
        logic [31:0] load_address;
        logic        wb_valid;
        logic [3:0]  wb_reg;
        logic [31:0] wb_value;
        logic        pc_loaded;
        logic        last;
    } result_t;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

endpackage

### hw/rtl/aldag_front.sv
// Front end: accepts instruction transfers and decodes them into queue entries.
module aldag_front
(
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [31:0]             instr_word,
    input  logic [31:0]             instr_address,
    input  logic [31:0]             base_value,
    input  aldag_pkg::queue_flags_t q_flags,
    output logic                    push,
    output aldag_pkg::op_t          op
);

    logic        is_lit;
    logic        is_imm;
    logic        is_ldm;
    logic        p_bit;
    logic        u_bit;
    logic        w_bit;
    logic        wback;
    logic [3:0]  rn;
    logic [3:0]  rt;
    logic [11:0] imm;
    logic [31:0] base_sel;
    logic [31:0] offset_addr;
    logic [15:0] reg_list;

    // Take a transfer whenever the queue has room
    assign in_ready = !q_flags.full;
    assign push     = in_valid && !q_flags.full;

    // Split the instruction fields
    assign p_bit    = instr_word[24];
    assign u_bit    = instr_word[23];
    assign w_bit    = instr_word[21];
    assign rn       = instr_word[19:16];
    assign rt       = instr_word[15:12];
    assign imm      = instr_word[11:0];
    assign reg_list = instr_word[15:0];
    assign wback    = !p_bit || w_bit;

    // Classify the encoding
    assign is_lit = (instr_word[27:24] == aldag_pkg::LIT_OPC) &&
                    (instr_word[22:16] == aldag_pkg::LIT_RN);
    assign is_imm = (instr_word[27:25] == aldag_pkg::LDR_OPC) && !instr_word[22] &&
                    instr_word[20];
    assign is_ldm = (instr_word[27:22] == aldag_pkg::LDM_OPC) && instr_word[20];

    // Shared offset adder for both single-load forms
    assign base_sel    = is_lit ? (instr_address + aldag_pkg::PC_AHEAD) : base_value;
    assign offset_addr = u_bit ? (base_sel + {20'd0, imm}) : (base_sel - {20'd0, imm});

    // Build the queue entry
    always_comb
    begin
        op        = '0;
        op.kind   = aldag_pkg::OP_SINGLE;
        op.status = aldag_pkg::ST_NO_MATCH;
        op.cond   = instr_word[31:28];
        if (is_lit)
        begin
            op.status       = aldag_pkg::ST_LOAD;
            op.dest_reg     = rt;
            op.load_address = offset_addr;
            op.pc_loaded    = (rt == aldag_pkg::PC_REG);
        end
        else if (is_imm)
        begin
            if (!p_bit && w_bit)
            begin
                op.status = aldag_pkg::ST_LDRT;
            end
            else if (wback && (rn == rt))
            begin
                op.status = aldag_pkg::ST_UNPRED;
            end
            else
            begin
                op.status       = aldag_pkg::ST_LOAD;
                op.dest_reg     = rt;
                op.load_address = p_bit ? offset_addr : base_value;
                op.wb_valid     = wback;
                op.wb_reg       = wback ? rn : 4'd0;
                op.wb_value     = wback ? offset_addr : 32'd0;
                op.pc_loaded    = (rt == aldag_pkg::PC_REG);
            end
        end
        else if (is_ldm)
        begin
            if ((rn == aldag_pkg::PC_REG) || (reg_list == 16'd0) ||
                (w_bit && reg_list[rn]))
            begin
                op.status = aldag_pkg::ST_UNPRED;
            end
            else
            begin
                op.kind         = aldag_pkg::OP_MULTI;
                op.status       = aldag_pkg::ST_LOAD;
                op.load_address = base_value;
                op.wb_valid     = w_bit;
                op.wb_reg       = w_bit ? rn : 4'd0;
                op.reg_list     = reg_list;
            end
        end
    end

endmodule

### hw/rtl/aldag_fifo.sv
// Small queue of decoded operations between front and back.
module aldag_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  aldag_pkg::op_t          din,
    input  logic                    pop,
    output aldag_pkg::op_t          dout,
    output aldag_pkg::queue_flags_t flags
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aldag_pkg::op_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign flags.full  = (count_reg == CW'(DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign dout        = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### hw/rtl/aldag_back.sv
// Back end: walks queued operations and drives one result per cycle into the output register while it is free.
module aldag_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  aldag_pkg::op_t          head,
    input  aldag_pkg::queue_flags_t q_flags,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output aldag_pkg::result_t      result
);

    logic                  out_valid_reg, out_valid_next;
    aldag_pkg::result_t    result_reg, result_next;
    logic                  started_reg, started_next;
    logic [15:0]           list_reg, list_next;
    logic [31:0]           addr_reg, addr_next;

    logic                  advance;
    logic                  load;
    logic [15:0]           list_cur;
    logic [15:0]           list_rest;
    logic [31:0]           addr_cur;
    logic [31:0]           addr_inc;
    logic [3:0]            low_idx;
    logic                  is_final;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Output register frees up when empty or when taken
    assign advance = !out_valid_reg || out_ready;
    assign load    = advance && !q_flags.empty;

    // Current step of a multiple load
    assign list_cur  = started_reg ? list_reg : head.reg_list;
    assign addr_cur  = started_reg ? addr_reg : head.load_address;
    assign list_rest = list_cur & (list_cur - 16'd1);
    assign addr_inc  = addr_cur + aldag_pkg::WORD_BYTES;
    assign is_final  = (list_rest == 16'd0);

    // Find the lowest listed register
    always_comb
    begin
        low_idx = 4'd0;
        for (int i = aldag_pkg::NUM_REGS - 1; i >= 0; i--)
        begin
            if (list_cur[i])
            begin
                low_idx = 4'(i);
            end
        end
    end

    // Form the next result and step state
    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        started_next   = started_reg;
        list_next      = list_reg;
        addr_next      = addr_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (head.kind == aldag_pkg::OP_MULTI)
            begin
                result_next              = '0;
                result_next.status       = aldag_pkg::ST_LOAD;
                result_next.cond         = head.cond;
                result_next.dest_reg     = low_idx;
                result_next.load_address = addr_cur;
                if (is_final)
                begin
                    result_next.wb_valid  = head.wb_valid;
                    result_next.wb_reg    = head.wb_reg;
                    result_next.wb_value  = head.wb_valid ? addr_inc : 32'd0;
                    result_next.pc_loaded = (low_idx == aldag_pkg::PC_REG);
                    result_next.last      = 1'b1;
                    started_next          = 1'b0;
                    pop                   = 1'b1;
                end
                else
                begin
                    started_next = 1'b1;
                    list_next    = list_rest;
                    addr_next    = addr_inc;
                end
            end
            else
            begin
                result_next.status       = head.status;
                result_next.cond         = head.cond;
                result_next.dest_reg     = head.dest_reg;
                result_next.load_address = head.load_address;
                result_next.wb_valid     = head.wb_valid;
                result_next.wb_reg       = head.wb_reg;
                result_next.wb_value     = head.wb_value;
                result_next.pc_loaded    = head.pc_loaded;
                result_next.last         = 1'b1;
                pop                      = 1'b1;
            end
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
        end
    end

    // Hold payload and walk state
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        list_reg   <= list_next;
        addr_reg   <= addr_next;
    end

endmodule

### hw/rtl/arm_load_decode_address_gen_top.sv
// Top level of the ARM load decoder and address generator.
//
// Input stream s_axis_*: one transfer per instruction, carrying the instruction
// word, its address and the value of its base register Rn.
// Output stream m_axis_*: load requests. A single LDR, or any rejected word,
// gives one transfer with tlast high. An LDM gives one transfer per listed
// register in ascending order; tlast, the writeback and the PC-branch flag
// ride on the last of them.
// A result passes through the queue and then the output register to m_axis.
// Throughput: one output transfer per cycle while the receiver takes them. The
// back end walks the register list of an LDM one entry per cycle. A queue
// of QUEUE_DEPTH decoded entries lets input transfers continue while an LDM
// is walked.
// Reset clears the queue and the output register; no transfer is pending.
// When the receiver stalls, the output holds and the queue fills, after which
// s_axis_tready drops until room frees up.
`include "assert_macros.svh"

module arm_load_decode_address_gen_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] instr_word, [63:32] instr_address, [95:64] base_value
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] cond, [7:4] dest_reg, [39:8] load_address, [40] wb_valid,
    // [44:41] wb_reg, [76:45] wb_value, [77] pc_loaded, [79:78] zero
    output logic [79:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    aldag_pkg::queue_flags_t q_flags;
    aldag_pkg::op_t          front_op;
    aldag_pkg::op_t          head_op;
    aldag_pkg::result_t      res;
    logic                    push;
    logic                    pop;

    aldag_front u_front
    (
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .instr_word    (s_axis_tdata[31:0]),
        .instr_address (s_axis_tdata[63:32]),
        .base_value    (s_axis_tdata[95:64]),
        .q_flags       (q_flags),
        .push          (push),
        .op            (front_op)
    );

    aldag_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_op),
        .pop   (pop),
        .dout  (head_op),
        .flags (q_flags)
    );

    aldag_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_op),
        .q_flags   (q_flags),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (res)
    );

    // Pack the result onto the stream
    assign m_axis_tdata = {2'b00, res.pc_loaded, res.wb_value, res.wb_reg, res.wb_valid,
                           res.load_address, res.dest_reg, res.cond};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

    // A rejected word yields exactly one result
    `ASSERT_IMPLY(a_reject_last, m_axis_tvalid && (m_axis_tuser != aldag_pkg::ST_LOAD),
                  m_axis_tlast)
    // A rejected word carries nothing but its condition field
    `ASSERT_IMPLY(a_reject_zero, m_axis_tvalid && (m_axis_tuser != aldag_pkg::ST_LOAD),
                  m_axis_tdata[79:4] == 76'd0)
    // Writeback and branch flag only on the final result
    `ASSERT_IMPLY(a_mid_clean, m_axis_tvalid && !m_axis_tlast,
                  !m_axis_tdata[40] && !m_axis_tdata[77])
    // Queue never reports full and empty together
    `ASSERT_ALWAYS(a_queue_flags, !(q_flags.full && q_flags.empty))

endmodule
